### hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl files
// every macro samples on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true at a clock edge
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### hw/rtl/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared types and constants of the DDA line rasterizer.
// ----------------------------------------------------------------------------
package dlr_pkg;

  // coordinate width fixed by the request and result fields
  localparam int COORD_W = 12;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_IDX_HEIGHT = 1'b0;
  localparam logic [COORD_W-1:0] HEIGHT_RESET = 12'd480;

  // request command codes
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_code_t;

  // input request
  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
  } in_item_t;

  // result
  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic               pixel_valid;
    logic               last_pixel;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    logic               is_start;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] abs_dx;
    logic [COORD_W-1:0] abs_dy;
    logic               neg_dx;
    logic               neg_dy;
    logic [COORD_W-1:0] steps;
  } work_t;

  // operands of the increment divider
  typedef struct packed {
    logic [COORD_W-1:0] num_x;
    logic [COORD_W-1:0] num_y;
    logic [COORD_W-1:0] den;
  } div_req_t;

  // back end sequencer states
  typedef enum logic {
    BK_READY  = 1'b0,
    BK_DIVIDE = 1'b1
  } back_state_t;

endpackage

### hw/rtl/dlr_fifo.sv
// ----------------------------------------------------------------------------
// dlr_fifo
// Small flop-based first-in first-out queue with a fill count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dlr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // status
  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({wr_en, rd_en})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `ASSERT_NEVER(a_fifo_overflow, wr_en && full && !rd_en, "fifo written while full")
  `ASSERT_NEVER(a_fifo_underflow, rd_en && empty, "fifo read while empty")
  `ASSERT_ALWAYS(a_fifo_count, count_r <= FULL_CNT, "fifo count beyond depth")

endmodule

### hw/rtl/dlr_front.sv
// ----------------------------------------------------------------------------
// dlr_front
// Accepts requests, classifies them and works out deltas and step count.
// ----------------------------------------------------------------------------
module dlr_front (
  input  logic              push,
  output logic              full,
  input  dlr_pkg::in_item_t in_item,
  input  logic              work_full,
  output logic              work_wr,
  output dlr_pkg::work_t    work
);

  import dlr_pkg::*;

  logic [COORD_W:0]   dx, dy;
  logic [COORD_W:0]   dx_neg, dy_neg;
  logic [COORD_W-1:0] ax, ay;

  // request handshake follows the work queue
  assign full    = work_full;
  assign work_wr = push && !work_full;

  // signed deltas and their magnitudes
  always_comb begin
    dx     = {1'b0, in_item.x_end} - {1'b0, in_item.x_start};
    dy     = {1'b0, in_item.y_end} - {1'b0, in_item.y_start};
    dx_neg = ~dx + 1'b1;
    dy_neg = ~dy + 1'b1;
    ax     = dx[COORD_W] ? dx_neg[COORD_W-1:0] : dx[COORD_W-1:0];
    ay     = dy[COORD_W] ? dy_neg[COORD_W-1:0] : dy[COORD_W-1:0];
  end

  // classified work item
  always_comb begin
    work.is_start = (in_item.cmd == CMD_START);
    work.x0       = in_item.x_start;
    work.y0       = in_item.y_start;
    work.abs_dx   = ax;
    work.abs_dy   = ay;
    work.neg_dx   = dx[COORD_W];
    work.neg_dy   = dy[COORD_W];
    work.steps    = (ax > ay) ? ax : ay;
  end

endmodule

### hw/rtl/dlr_div.sv
// ----------------------------------------------------------------------------
// dlr_div
// Radix-2 restoring divider for both increments, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dlr_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  dlr_pkg::div_req_t  req,
  output logic               done,
  output logic [FRAC_BITS:0] quo_x,
  output logic [FRAC_BITS:0] quo_y
);

  import dlr_pkg::*;

  // numerator never exceeds the divisor, so the quotient has FRAC_BITS+1 bits
  localparam int ITER  = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(ITER + 1);
  localparam logic [CNT_W-1:0] ITER_C = CNT_W'(ITER);

  logic [COORD_W-1:0] rem_x_r, rem_x_nxt;
  logic [COORD_W-1:0] rem_y_r, rem_y_nxt;
  logic [COORD_W-1:0] den_r;
  logic [FRAC_BITS:0] quo_x_r, quo_x_nxt;
  logic [FRAC_BITS:0] quo_y_r, quo_y_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               first_r, first_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic               bit_x, bit_y;

  // one restoring step: remainder stays below the divisor
  function automatic logic [COORD_W:0] div_step(
    input logic [COORD_W-1:0] rem,
    input logic [COORD_W-1:0] den,
    input logic               first
  );
    logic [COORD_W:0] t;
    logic [COORD_W:0] d;
    t = first ? {1'b0, rem} : {rem, 1'b0};
    d = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      div_step = {1'b1, d[COORD_W-1:0]};
    end else begin
      div_step = {1'b0, t[COORD_W-1:0]};
    end
  endfunction

  assign done  = done_r;
  assign quo_x = quo_x_r;
  assign quo_y = quo_y_r;

  // iteration
  always_comb begin
    {bit_x, rem_x_nxt} = div_step(rem_x_r, den_r, first_r);
    {bit_y, rem_y_nxt} = div_step(rem_y_r, den_r, first_r);
    quo_x_nxt = {quo_x_r[FRAC_BITS-1:0], bit_x};
    quo_y_nxt = {quo_y_r[FRAC_BITS-1:0], bit_y};
    cnt_nxt   = cnt_r - 1'b1;
    first_nxt = 1'b0;
    busy_nxt  = (cnt_r != CNT_W'(1));
    done_nxt  = (cnt_r == CNT_W'(1));
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= ITER_C;
    end else if (busy_r) begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end else begin
      done_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_x_r <= req.num_x;
      rem_y_r <= req.num_y;
      den_r   <= req.den;
      first_r <= 1'b1;
    end else if (busy_r) begin
      rem_x_r <= rem_x_nxt;
      rem_y_r <= rem_y_nxt;
      quo_x_r <= quo_x_nxt;
      quo_y_r <= quo_y_nxt;
      first_r <= first_nxt;
    end
  end

  `ASSERT_NEVER(a_div_restart, start && busy_r, "divider started while busy")
  `ASSERT_ALWAYS(a_div_done_src, done_r |-> $past(busy_r), "done without a running division")
  `ASSERT_ALWAYS(a_div_rem, busy_r && !first_r |-> rem_x_r < den_r && rem_y_r < den_r,
                 "remainder not below divisor")

endmodule

### hw/rtl/dlr_back.sv
// ----------------------------------------------------------------------------
// dlr_back
// Executes work items: sets up lines, steps the accumulators, forms pixels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dlr_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dlr_pkg::work_t                  work,
  input  logic                            work_empty,
  output logic                            work_rd,
  input  logic                            res_full,
  output logic                            res_wr,
  output dlr_pkg::out_item_t              res,
  input  logic [dlr_pkg::COORD_W-1:0]     screen_height,
  output logic                            div_start,
  output dlr_pkg::div_req_t               div_req,
  input  logic                            div_done,
  input  logic [FRAC_BITS:0]              div_quo_x,
  input  logic [FRAC_BITS:0]              div_quo_y
);

  import dlr_pkg::*;

  // accumulators carry a built-in half so rounding is a plain truncation
  localparam int ACC_W  = COORD_W + FRAC_BITS;
  localparam int STEP_W = FRAC_BITS + 2;

  back_state_t        state_r, state_nxt;
  logic [ACC_W-1:0]   acc_x_r, acc_y_r;
  logic [STEP_W-1:0]  step_x_r, step_y_r;
  logic [COORD_W-1:0] left_r;
  logic               active_r;
  logic               neg_x_r, neg_y_r;

  logic               go;
  logic               launch;
  logic [ACC_W-1:0]   sum_x, sum_y;
  logic [ACC_W-1:0]   base_x, base_y;
  logic [COORD_W-1:0] ry;
  logic [COORD_W:0]   fy_diff;
  logic [COORD_W-1:0] fy;
  logic [STEP_W-1:0]  ext_x, ext_y;

  // take a work item when idle and the result queue has room
  assign go     = (state_r == BK_READY) && !work_empty && !res_full;
  assign launch = go && work.is_start && (work.steps != '0);

  // next accumulator values
  always_comb begin
    sum_x  = acc_x_r + {{(ACC_W-STEP_W){step_x_r[STEP_W-1]}}, step_x_r};
    sum_y  = acc_y_r + {{(ACC_W-STEP_W){step_y_r[STEP_W-1]}}, step_y_r};
    base_x = {work.x0, 1'b1, {(FRAC_BITS-1){1'b0}}};
    base_y = {work.y0, 1'b1, {(FRAC_BITS-1){1'b0}}};
  end

  // y flip against the window height, clamped at zero
  always_comb begin
    ry      = work.is_start ? work.y0 : sum_y[ACC_W-1 -: COORD_W];
    fy_diff = {1'b0, screen_height} - {1'b0, ry};
    fy      = fy_diff[COORD_W] ? '0 : fy_diff[COORD_W-1:0];
  end

  // result fields
  always_comb begin
    res = '0;
    if (work.is_start) begin
      res.pixel_x     = work.x0;
      res.pixel_y     = fy;
      res.pixel_valid = 1'b1;
      res.last_pixel  = (work.steps == '0);
    end else if (active_r) begin
      res.pixel_x     = sum_x[ACC_W-1 -: COORD_W];
      res.pixel_y     = fy;
      res.pixel_valid = 1'b1;
      res.last_pixel  = (left_r == COORD_W'(1));
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_READY: begin
        if (launch) begin
          state_nxt = BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        if (div_done) begin
          state_nxt = BK_READY;
        end
      end
      default: state_nxt = BK_READY;
    endcase
  end

  // sequencer outputs
  always_comb begin
    work_rd       = go;
    res_wr        = go;
    div_start     = launch;
    div_req.num_x = work.abs_dx;
    div_req.num_y = work.abs_dy;
    div_req.den   = work.steps;
  end

  // signed increments from the quotients
  always_comb begin
    ext_x = {1'b0, div_quo_x};
    ext_y = {1'b0, div_quo_y};
    if (neg_x_r) begin
      ext_x = STEP_W'(0) - ext_x;
    end
    if (neg_y_r) begin
      ext_y = STEP_W'(0) - ext_y;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_READY;
      active_r <= 1'b0;
      left_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (go && work.is_start) begin
        active_r <= (work.steps != '0);
        left_r   <= work.steps;
      end else if (go && active_r) begin
        active_r <= (left_r != COORD_W'(1));
        left_r   <= left_r - 1'b1;
      end
    end
  end

  // line datapath
  always_ff @(posedge clk) begin
    if (go && work.is_start) begin
      acc_x_r <= base_x;
      acc_y_r <= base_y;
      neg_x_r <= work.neg_dx;
      neg_y_r <= work.neg_dy;
    end else if (go && active_r) begin
      acc_x_r <= sum_x;
      acc_y_r <= sum_y;
    end
    if (div_done) begin
      step_x_r <= ext_x;
      step_y_r <= ext_y;
    end
  end

  `ASSERT_NEVER(a_back_res_full, res_wr && res_full, "result pushed into a full queue")
  `ASSERT_ALWAYS(a_back_launch, div_start |=> state_r == BK_DIVIDE, "divide not entered")
  `ASSERT_ALWAYS(a_back_left, active_r |-> left_r != '0, "active line with no steps left")
  `ASSERT_NEVER(a_back_done, div_done && state_r != BK_DIVIDE, "divider done while not waiting")

endmodule

### hw/rtl/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer: start requests set up a line, step requests emit pixels.
// ----------------------------------------------------------------------------
// Requests enter through push/full and are accepted when push is high and
// full is low. Results leave through empty/pop: the oldest result sits on
// out_item while empty is low and is taken when pop is high. Every request
// gives exactly one result. The user must write the window height over the
// APB port at byte address 0 only while idle; the block does not enforce it.
// An accepted request is registered in the work queue, and its result in
// the result queue when the back end takes it. Step requests run at one
// pixel per cycle, one accumulator add each, while the result queue has
// room. A start request of nonzero length holds the back end until the
// bit-serial increment divider is done.
// Reset empties both queues, drops any line in progress and sets the
// height to 480. When the receiver stops popping, the result queue fills,
// the back end holds, and full rises once the request queue is also full.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
  parameter int FRAC_BITS = 16,
  parameter int CMD_DEPTH = 2,
  parameter int RES_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              push,
  output logic                              full,
  input  dlr_pkg::in_item_t                 in_item,
  // result channel
  output logic                              empty,
  input  logic                              pop,
  output dlr_pkg::out_item_t                out_item,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dlr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [dlr_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [dlr_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  import dlr_pkg::*;

  logic [COORD_W-1:0] height_r, height_nxt;
  logic               cfg_wr;

  work_t              work_in, work_out;
  logic               work_wr, work_full, work_rd, work_empty;
  out_item_t          res;
  logic               res_wr, res_full;
  logic               div_start, div_done;
  div_req_t           div_req;
  logic [FRAC_BITS:0] quo_x, quo_y;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[CFG_ADDR_W-1] == REG_IDX_HEIGHT) ? CFG_DATA_W'(height_r) : '0;

  always_comb begin
    height_nxt = height_r;
    if (cfg_wr && (paddr[CFG_ADDR_W-1] == REG_IDX_HEIGHT)) begin
      height_nxt = pwdata[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= HEIGHT_RESET;
    end else begin
      height_r <= height_nxt;
    end
  end

  // front end
  dlr_front u_front (
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .work_full (work_full),
    .work_wr   (work_wr),
    .work      (work_in)
  );

  // queue between front and back
  dlr_fifo #(
    .WIDTH ($bits(work_t)),
    .DEPTH (CMD_DEPTH)
  ) u_work_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (work_wr),
    .wr_data (work_in),
    .full    (work_full),
    .rd_en   (work_rd),
    .rd_data (work_out),
    .empty   (work_empty)
  );

  // back end
  dlr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .work          (work_out),
    .work_empty    (work_empty),
    .work_rd       (work_rd),
    .res_full      (res_full),
    .res_wr        (res_wr),
    .res           (res),
    .screen_height (height_r),
    .div_start     (div_start),
    .div_req       (div_req),
    .div_done      (div_done),
    .div_quo_x     (quo_x),
    .div_quo_y     (quo_y)
  );

  // increment divider
  dlr_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .quo_x (quo_x),
    .quo_y (quo_y)
  );

  // result queue
  dlr_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop && !empty),
    .rd_data (out_item),
    .empty   (empty)
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the DDA line rasterizer.
// Line requests go in through the push/full queue and pixels are popped
// from the result queue. Every accepted request runs through a local
// fixed-point DDA model, and each popped pixel is compared field by field
// with the oldest predicted one. The window height is set over APB between
// traffic phases, and the result side stalls for a long stretch once so
// that the request side backs up.
// ----------------------------------------------------------------------------
module testbench;
  import dlr_pkg::*;

  localparam int FRAC_W = 16;
  localparam int HALF_LSB = 1 << (FRAC_W - 1);
  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam int IN_W = $bits(in_item_t);
  localparam logic [CFG_ADDR_W-1:0] HEIGHT_ADDR = CFG_ADDR_W'(4 * REG_IDX_HEIGHT);
  // first address past the only register, writes there must be dropped
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = CFG_ADDR_W'(HEIGHT_ADDR + 4);
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = FRAC_W + 8;
  localparam int PHASE_PIXELS = 400;
  localparam int TIMEOUT_NS = 5_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  in_item_t in_item = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  // idle rates of both sides, in percent
  int send_gap_pct = 0;
  int pop_gap_pct = 0;
  logic hold_req = 1'b0;
  int hold_left = 0;

  // predicted pixels in request order
  out_item_t pending_pixels[$];

  // line model state
  logic [COORD_W-1:0] pm_height;
  int pm_pos_x, pm_pos_y;
  int pm_inc_x, pm_inc_y;
  logic [COORD_W-1:0] pm_left;
  bit pm_active;

  int n_errors = 0;
  int n_lines = 0;
  int n_pixels = 0;
  int n_blank = 0;
  int n_line_ends = 0;
  int n_full_waits = 0;

  dda_line_rasterizer #(.FRAC_BITS(FRAC_W)) dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("testbench: errors");
    $finish;
  end

  task automatic report_error(input string msg);
    n_errors++;
    if (n_errors <= 40) $display("error at %0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------- model

  // signed per-step increment, magnitude truncated
  function automatic int increment(input int d, input int span);
    int mag;
    if (span == 0) return 0;
    mag = ((d < 0) ? -d : d) << FRAC_W;
    mag = mag / span;
    return (d < 0) ? -mag : mag;
  endfunction

  // round half away from zero, keep the coordinate bits
  function automatic logic [COORD_W-1:0] round_coord(input int p);
    int mag;
    if (p >= 0) begin
      mag = (p + HALF_LSB) >>> FRAC_W;
      return mag[COORD_W-1:0];
    end
    mag = (-p + HALF_LSB) >>> FRAC_W;
    mag = -mag;
    return mag[COORD_W-1:0];
  endfunction

  function automatic out_item_t place_pixel(input bit last);
    out_item_t px;
    logic [COORD_W-1:0] ry;
    ry = round_coord(pm_pos_y);
    px.pixel_x = round_coord(pm_pos_x);
    px.pixel_y = (pm_height >= ry) ? pm_height - ry : '0;
    px.pixel_valid = 1'b1;
    px.last_pixel = last;
    return px;
  endfunction

  // advance the line model by one request and give its pixel
  function automatic out_item_t rasterize(input in_item_t req);
    int dx, dy, ax, ay, span;
    out_item_t px;
    px = '0;
    if (req.cmd == CMD_START) begin
      dx = int'(req.x_end) - int'(req.x_start);
      dy = int'(req.y_end) - int'(req.y_start);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      span = (ax > ay) ? ax : ay;
      pm_inc_x = increment(dx, span);
      pm_inc_y = increment(dy, span);
      pm_pos_x = int'(req.x_start) << FRAC_W;
      pm_pos_y = int'(req.y_start) << FRAC_W;
      pm_left = span[COORD_W-1:0];
      pm_active = (pm_left != 0);
      return place_pixel(!pm_active);
    end
    if (!pm_active) return px;
    pm_pos_x += pm_inc_x;
    pm_pos_y += pm_inc_y;
    pm_left = pm_left - 1'b1;
    if (pm_left == 0) pm_active = 1'b0;
    return place_pixel(!pm_active);
  endfunction

  // ---------------------------------------------------------------- request side

  task automatic push_request(input in_item_t req);
    out_item_t px;
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    push <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (full) begin
      n_full_waits++;
      @(posedge clk);
    end
    px = rasterize(req);
    pending_pixels.push_back(px);
    if (req.cmd == CMD_START) n_lines++;
    if (px.pixel_valid) n_pixels++;
    else n_blank++;
    if (px.last_pixel) n_line_ends++;
  endtask

  task automatic send_start(input int x0, input int y0, input int x1, input int y1);
    in_item_t req;
    req.cmd = CMD_START;
    req.x_start = x0[COORD_W-1:0];
    req.y_start = y0[COORD_W-1:0];
    req.x_end = x1[COORD_W-1:0];
    req.y_end = y1[COORD_W-1:0];
    push_request(req);
  endtask

  // endpoint fields are ignored on a step, so they carry noise
  task automatic send_step();
    in_item_t req;
    req = IN_W'({$urandom, $urandom});
    req.cmd = CMD_STEP;
    push_request(req);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  // ---------------------------------------------------------------- result side

  task automatic check_pixel(input out_item_t got);
    out_item_t want;
    if (pending_pixels.size() == 0) begin
      report_error("pixel popped with no request waiting");
      return;
    end
    want = pending_pixels.pop_front();
    if (got.pixel_x !== want.pixel_x)
      report_error($sformatf("pixel_x expected %0d got %0d", want.pixel_x, got.pixel_x));
    if (got.pixel_y !== want.pixel_y)
      report_error($sformatf("pixel_y expected %0d got %0d", want.pixel_y, got.pixel_y));
    if (got.pixel_valid !== want.pixel_valid)
      report_error($sformatf("pixel_valid expected %0b got %0b",
                             want.pixel_valid, got.pixel_valid));
    if (got.last_pixel !== want.last_pixel)
      report_error($sformatf("last_pixel expected %0b got %0b",
                             want.last_pixel, got.last_pixel));
  endtask

  // check popped pixels, then drive pop with random stalls or a long hold
  always @(posedge clk) begin
    if (rst_n && pop && !empty) check_pixel(out_item);
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      pop <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else begin
      pop <= ($urandom_range(99) >= pop_gap_pct);
    end
  end

  // ---------------------------------------------------------------- config port

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == HEIGHT_ADDR) pm_height = data[COORD_W-1:0];
  endtask

  // read the height back and compare with the model
  task automatic cfg_check_height();
    logic [CFG_DATA_W-1:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= HEIGHT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    want = CFG_DATA_W'(pm_height);
    if (prdata !== want)
      report_error($sformatf("height readback expected %0d got %0d", want, prdata));
  endtask

  task automatic cfg_idle();
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_height(input int h);
    wait_drained();
    cfg_write(HEIGHT_ADDR, CFG_DATA_W'(h));
    cfg_check_height();
    cfg_idle();
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic int near(input int c, input int span);
    int v;
    v = c + int'($urandom_range(2 * span)) - span;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  // one line with random content: mostly run to the end, sometimes cut
  // short by the next start, sometimes stepped past its end
  task automatic random_line();
    int pick, span, x0, y0, count, extra;
    pick = $urandom_range(99);
    if (pick < 5) span = COORD_MAX;
    else if (pick < 20) span = $urandom_range(200, 25);
    else span = $urandom_range(24, 0);
    x0 = $urandom_range(COORD_MAX);
    y0 = $urandom_range(COORD_MAX);
    send_start(x0, y0, near(x0, span), near(y0, span));
    count = pm_left;
    extra = 0;
    pick = $urandom_range(99);
    if (count > 40) count = $urandom_range(40, 1);
    else if (pick < 15) count = $urandom_range(count, 0);
    else if (pick < 30) extra = $urandom_range(3, 1);
    repeat (count) send_step();
    repeat (extra) send_step();
  endtask

  // reset value of the height and a write to an unmapped address
  task automatic test_config_port();
    cfg_check_height();
    cfg_write(SPARE_ADDR, 32'h0000_0123);
    cfg_check_height();
    cfg_idle();
  endtask

  task automatic test_directed_lines();
    // step with no line in progress
    send_step();
    // zero-length line at the far corner, then a step past it
    send_start(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_step();
    // full diagonal, abandoned by a new start along the other diagonal
    send_start(0, 0, COORD_MAX, COORD_MAX);
    repeat (2) send_step();
    send_start(COORD_MAX, 0, 0, COORD_MAX);
    repeat (2) send_step();
    // negative y slope run to the end and one step beyond
    send_start(10, 20, 13, 12);
    repeat (9) send_step();
    // half-pixel increments exercise the rounding
    send_start(0, 0, 4, 2);
    repeat (4) send_step();
  endtask

  task automatic run_phase(input int send_pct, input int pop_pct);
    int goal;
    send_gap_pct = send_pct;
    pop_gap_pct = pop_pct;
    goal = n_pixels + PHASE_PIXELS;
    while (n_pixels < goal) random_line();
  endtask

  task automatic test_random_traffic();
    set_height(0);
    run_phase(34, 85);
    set_height(COORD_MAX);
    run_phase(85, 34);
    set_height($urandom_range(COORD_MAX - 1, 1));
    run_phase(0, 0);
  endtask

  // receiver stops for a long stretch while requests keep coming
  task automatic test_result_backpressure();
    wait_drained();
    send_gap_pct = 0;
    pop_gap_pct = 0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    send_start(100, 100, 130, 110);
    repeat (30) send_step();
  endtask

  initial begin
    pm_height = HEIGHT_RESET;
    pm_pos_x = 0;
    pm_pos_y = 0;
    pm_inc_x = 0;
    pm_inc_y = 0;
    pm_left = '0;
    pm_active = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_config_port();
    test_directed_lines();
    test_random_traffic();
    test_result_backpressure();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d lines, %0d pixels, %0d line ends, %0d steps with no line",
             n_lines, n_pixels, n_line_ends, n_blank);
    $display("heights 480, 0, max and random; request side held off by full for %0d cycles",
             n_full_waits);
    if (n_errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/dlr_pkg.sv
hw/rtl/dlr_fifo.sv
hw/rtl/dlr_front.sv
hw/rtl/dlr_div.sv
hw/rtl/dlr_back.sv
hw/rtl/dda_line_rasterizer.sv
tb/testbench.sv
